FILE: rtl/core/tdc_pkg.sv
// tdc_pkg: types, codes and constants shared by the thermostat controller
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none
package tdc_pkg;

  localparam int TEMP_BITS = 11;

  // request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_RAISE  = 2'd1;
  localparam logic [1:0] REQ_LOWER  = 2'd2;
  localparam logic [1:0] REQ_SERIAL = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_SETPOINT_MIN = 2'd0;
  localparam logic [1:0] CFG_SETPOINT_MAX = 2'd1;
  localparam logic [1:0] CFG_DEADBAND     = 2'd2;
  localparam logic [1:0] CFG_TICK_PERIOD  = 2'd3;

  // reset values
  localparam logic [7:0] SETPOINT_MIN_RST = 8'd10;
  localparam logic [7:0] SETPOINT_MAX_RST = 8'd50;
  localparam logic [7:0] DEADBAND_RST     = 8'd1;
  localparam logic [7:0] TICK_PERIOD_RST  = 8'd10;
  localparam logic [7:0] SETPOINT_RST     = 8'd30;

  // characters
  localparam logic [7:0] CMD_RAISE    = 8'h41; // 'A'
  localparam logic [7:0] CMD_LOWER    = 8'h42; // 'B'
  localparam logic [7:0] CMD_REPORT   = 8'h54; // 'T'
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_O       = 8'h4F;
  localparam logic [7:0] CHAR_K       = 8'h4B;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // reply positions
  localparam logic [2:0] POS_TENS    = 3'd0;
  localparam logic [2:0] POS_UNITS   = 3'd1;
  localparam logic [2:0] POS_SPACE_A = 3'd2;
  localparam logic [2:0] POS_ECHO    = 3'd3;
  localparam logic [2:0] POS_SPACE_B = 3'd4;
  localparam logic [2:0] POS_O       = 3'd5;
  localparam logic [2:0] POS_K       = 3'd6;
  localparam logic [2:0] POS_NEWLINE = 3'd7;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [7:0]           rx_byte;
    logic [TEMP_BITS-1:0] temp_first;
    logic [TEMP_BITS-1:0] temp_second;
    logic                 first_missing;
    logic                 second_missing;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       cooler_relay;
    logic       heater_relay;
    logic [7:0] setpoint_now;
    logic [7:0] average_now;
    logic       last;
  } result_t;

  // work handed from the front to the back
  typedef struct packed {
    logic       is_serial;
    logic       has_report;
    logic [7:0] ch;
    logic       cooler;
    logic       heater;
    logic [7:0] setpoint;
    logic [7:0] average;
  } job_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  // decimal tens and units of an 8-bit value (hundreds dropped)
  function automatic digits_t to_digits(input logic [7:0] v);
    logic [7:0] r;
    logic [3:0] t;
    logic [7:0] u;
    digits_t    d;
    r = v;
    if (r >= 8'd200) begin
      r = r - 8'd200;
    end else if (r >= 8'd100) begin
      r = r - 8'd100;
    end
    t = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (r >= 8'(i * 10)) t = 4'(i);
    end
    u = r - ({4'd0, t} * 8'd10);
    d.tens  = t;
    d.units = u[3:0];
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tdc_front.sv
// tdc_front: takes requests, keeps setpoint, divider, average and relays,
// writes one job per request into the queue. depends on: tdc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tdc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tdc_pkg::item_t item,
  input  wire logic           q_full,
  output tdc_pkg::job_t       q_data,
  output logic                q_wr,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [7:0]     cfg_data
);
  import tdc_pkg::*;

  logic [7:0] setpoint_min, setpoint_max, deadband, tick_period;
  logic [7:0] setpoint, setpoint_next;
  logic [7:0] tick_count, tick_count_next;
  logic [7:0] average, average_next;
  logic       cooler_level, cooler_level_next;
  logic       heater_level, heater_level_next;

  logic                 accept;
  logic                 have1, have2;
  logic [TEMP_BITS:0]   sum, whole;
  logic [7:0]           avg_new;
  logic [8:0]           inc;
  logic [7:0]           raise_val, lower_val, dec;

  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;
  assign q_wr      = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_min <= SETPOINT_MIN_RST;
      setpoint_max <= SETPOINT_MAX_RST;
      deadband     <= DEADBAND_RST;
      tick_period  <= TICK_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SETPOINT_MIN: setpoint_min <= cfg_data;
        CFG_SETPOINT_MAX: setpoint_max <= cfg_data;
        CFG_DEADBAND:     deadband     <= cfg_data;
        CFG_TICK_PERIOD:  tick_period  <= cfg_data;
      endcase
    end
  end

  always_comb begin
    have1 = !item.first_missing;
    have2 = !item.second_missing;
    sum   = {1'b0, item.temp_first} + {1'b0, item.temp_second};
    if (have1 && have2) begin
      whole = sum >> 5;
    end else if (have1) begin
      whole = {1'b0, item.temp_first} >> 4;
    end else begin
      whole = {1'b0, item.temp_second} >> 4;
    end
    avg_new = (whole > (TEMP_BITS+1)'(255)) ? 8'hFF : whole[7:0];

    inc       = {1'b0, setpoint} + 9'd1;
    raise_val = (inc > {1'b0, setpoint_max}) ? setpoint_max : inc[7:0];
    dec       = setpoint - 8'd1;
    lower_val = (setpoint == 8'd0 || dec < setpoint_min) ? setpoint_min : dec;
  end

  always_comb begin
    setpoint_next     = setpoint;
    tick_count_next   = tick_count;
    average_next      = average;
    cooler_level_next = cooler_level;
    heater_level_next = heater_level;
    unique case (item.req_type)
      REQ_TICK: begin
        if (tick_count > tick_period) begin
          // cleared then counted, so one after a decision
          tick_count_next = 8'd1;
          if (have1 || have2) begin
            average_next = avg_new;
            if (avg_new > setpoint) begin
              cooler_level_next = !((avg_new - setpoint) > deadband);
            end else begin
              heater_level_next = !((setpoint - avg_new) > deadband);
            end
          end
        end else if (tick_count != 8'hFF) begin
          tick_count_next = tick_count + 8'd1;
        end
      end
      REQ_RAISE: setpoint_next = raise_val;
      REQ_LOWER: setpoint_next = lower_val;
      REQ_SERIAL: begin
        if (item.rx_byte == CMD_RAISE) setpoint_next = raise_val;
        if (item.rx_byte == CMD_LOWER) setpoint_next = lower_val;
      end
    endcase
  end

  always_comb begin
    q_data.is_serial  = (item.req_type == REQ_SERIAL);
    q_data.has_report = (item.req_type == REQ_SERIAL) && (item.rx_byte == CMD_REPORT);
    q_data.ch         = item.rx_byte;
    q_data.cooler     = cooler_level_next;
    q_data.heater     = heater_level_next;
    q_data.setpoint   = setpoint_next;
    q_data.average    = average_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint     <= SETPOINT_RST;
      tick_count   <= 8'd0;
      average      <= 8'd0;
      cooler_level <= 1'b1;
      heater_level <= 1'b1;
    end else if (accept) begin
      setpoint     <= setpoint_next;
      tick_count   <= tick_count_next;
      average      <= average_next;
      cooler_level <= cooler_level_next;
      heater_level <= heater_level_next;
    end
  end

  a_tick_nonzero: assert property (@(posedge clk) disable iff (rst)
    $past(accept) && $past(item.req_type == REQ_TICK) && !$past(rst)
      |-> tick_count != 8'd0)
    else $error("divider is zero after a tick");

endmodule
`default_nettype wire

FILE: rtl/core/tdc_queue.sv
// tdc_queue: small job queue between the front and the back
// depends on: tdc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tdc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire tdc_pkg::job_t wr_data,
  output logic               full,
  input  wire logic          rd,
  output tdc_pkg::job_t      rd_data,
  output logic               empty
);
  import tdc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

endmodule
`default_nettype wire

FILE: rtl/core/tdc_back.sv
// tdc_back: expands each job into its results, one a cycle unless the
// receiver stalls, into the output register. depends on: tdc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tdc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire tdc_pkg::job_t job,
  output logic               head_pop,
  output logic               empty,
  input  wire logic          pop,
  output tdc_pkg::result_t   result
);
  import tdc_pkg::*;

  logic       out_valid;
  logic [2:0] step;
  logic [2:0] pos;
  logic       last_step;
  logic       load;
  digits_t    dg;
  result_t    res_next;

  assign empty = !out_valid;
  assign load  = head_valid && (!out_valid || pop);

  always_comb begin
    // plain echo replies skip the report part
    pos       = job.has_report ? step : 3'(step + 3'd3);
    last_step = !job.is_serial || (pos == POS_NEWLINE);
    head_pop  = load && last_step;
    dg        = to_digits(job.average);

    res_next.tx_valid     = job.is_serial;
    res_next.cooler_relay = job.cooler;
    res_next.heater_relay = job.heater;
    res_next.setpoint_now = job.setpoint;
    res_next.average_now  = job.average;
    res_next.last         = last_step;
    res_next.tx_char      = 8'd0;
    if (job.is_serial) begin
      unique case (pos)
        POS_TENS:    res_next.tx_char = CHAR_ZERO + {4'd0, dg.tens};
        POS_UNITS:   res_next.tx_char = CHAR_ZERO + {4'd0, dg.units};
        POS_SPACE_A: res_next.tx_char = CHAR_SPACE;
        POS_ECHO:    res_next.tx_char = job.ch;
        POS_SPACE_B: res_next.tx_char = CHAR_SPACE;
        POS_O:       res_next.tx_char = CHAR_O;
        POS_K:       res_next.tx_char = CHAR_K;
        POS_NEWLINE: res_next.tx_char = CHAR_NEWLINE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        step <= last_step ? 3'd0 : step + 3'd1;
      end
    end
  end

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> step == 3'd0)
    else $error("reply step left over with no job");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> load && head_valid)
    else $error("job retired without a result");

endmodule
`default_nettype wire

FILE: rtl/core/thermostat_deadband_controller.sv
// thermostat_deadband_controller: top level of the thermostat controller
// depends on: tdc_pkg, tdc_front, tdc_queue, tdc_back
//
// Usage
//   Requests enter as a queue: item is taken at a clock edge with push high
//   and full low. Results leave as a queue: while empty is low, result holds
//   the oldest result, and it is taken at an edge with pop high.
//   Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
//   cfg_ready is always high. Write them only while the block is idle.
//   Tick, raise and lower requests give one result each. A serial byte gives
//   five results, or eight for the report command, one per cycle while pop
//   is high. A request's job is written into the job queue, then its first
//   result is loaded into the output register. Throughput: one request a
//   cycle for single-result requests while full is low; a serial request
//   occupies the result side for five or eight results. The front keeps
//   taking requests until the job queue (QUEUE_DEPTH entries) fills.
//   Reset: setpoint 30, divider and average 0, both relays off, bounds and
//   period to their defaults, queues empty.
//   A stalled receiver holds the result in the output register; the queue
//   then fills and full rises. No result is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module thermostat_deadband_controller #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire tdc_pkg::item_t   item,
  output logic                  empty,
  input  wire logic             pop,
  output tdc_pkg::result_t      result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_data
);
  import tdc_pkg::*;

  job_t wr_job, head_job;
  logic q_wr, q_full, q_empty, q_rd;

  assign full = q_full;

  tdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .q_full    (q_full),
    .q_data    (wr_job),
    .q_wr      (q_wr),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (wr_job),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (head_job),
    .empty   (q_empty)
  );

  tdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!q_empty),
    .job        (head_job),
    .head_pop   (q_rd),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
`default_nettype wire
